// ===== rtl/oadc_pkg.sv =====
package oadc_pkg;

  // Field widths
  localparam int unsigned DistW   = 9;
  localparam int unsigned CmdW    = 8;
  localparam int unsigned MsW     = 16;
  localparam int unsigned SpeedW  = 10;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ActW    = 3;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // Packed stream widths, rounded up to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  // Reset values
  localparam logic [DistW-1:0]  RST_OBSTACLE = DistW'(10);
  localparam logic [DistW-1:0]  RST_CORNER   = DistW'(12);
  localparam logic [MsW-1:0]    RST_REVERSE  = MsW'(2000);
  localparam logic [MsW-1:0]    RST_RELEASE  = MsW'(3000);
  localparam logic [SpeedW-1:0] RST_CRUISE   = SpeedW'(500);
  localparam logic [SpeedW-1:0] RST_AVOID    = SpeedW'(600);
  localparam logic [SpeedW-1:0] RST_MTURN    = SpeedW'(700);
  localparam logic [DistW-1:0]  RST_DIST     = DistW'(100);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_OBSTACLE = 3'd0,
    CFG_CORNER   = 3'd1,
    CFG_REVERSE  = 3'd2,
    CFG_RELEASE  = 3'd3,
    CFG_CRUISE   = 3'd4,
    CFG_AVOID    = 3'd5,
    CFG_MTURN    = 3'd6
  } cfg_idx_e;

  // Event kinds
  typedef enum logic [ModeW-1:0] {
    MODE_TICK   = 2'd0,
    MODE_DIST   = 2'd1,
    MODE_BUTTON = 2'd2,
    MODE_CMD    = 2'd3
  } mode_e;

  // Motor actions
  typedef enum logic [ActW-1:0] {
    ACT_STOP  = 3'd0,
    ACT_FWD   = 3'd1,
    ACT_BACK  = 3'd2,
    ACT_LEFT  = 3'd3,
    ACT_RIGHT = 3'd4
  } action_e;

  typedef struct packed {
    logic [DistW-1:0]  obstacle_distance;
    logic [DistW-1:0]  corner_distance;
    logic [MsW-1:0]    stuck_reverse_ms;
    logic [MsW-1:0]    stuck_release_ms;
    logic [SpeedW-1:0] cruise_speed;
    logic [SpeedW-1:0] avoid_speed;
    logic [SpeedW-1:0] manual_turn_speed;
  } cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic [DistW-1:0] left_cm;
    logic [DistW-1:0] front_cm;
    logic [DistW-1:0] right_cm;
    logic [CmdW-1:0]  command_byte;
  } item_t;

  typedef struct packed {
    action_e           motor_action;
    logic [SpeedW-1:0] motor_speed;
  } result_t;

endpackage

// ===== rtl/oadc_cfg_regs.sv =====
module oadc_cfg_regs
  import oadc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [CfgDatW-1:0] wr_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; indexes past the list leave everything as is
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_OBSTACLE: cfg_nxt.obstacle_distance = wr_data[DistW-1:0];
        CFG_CORNER:   cfg_nxt.corner_distance   = wr_data[DistW-1:0];
        CFG_REVERSE:  cfg_nxt.stuck_reverse_ms  = wr_data[MsW-1:0];
        CFG_RELEASE:  cfg_nxt.stuck_release_ms  = wr_data[MsW-1:0];
        CFG_CRUISE:   cfg_nxt.cruise_speed      = wr_data[SpeedW-1:0];
        CFG_AVOID:    cfg_nxt.avoid_speed       = wr_data[SpeedW-1:0];
        CFG_MTURN:    cfg_nxt.manual_turn_speed = wr_data[SpeedW-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.obstacle_distance <= RST_OBSTACLE;
      cfg_r.corner_distance   <= RST_CORNER;
      cfg_r.stuck_reverse_ms  <= RST_REVERSE;
      cfg_r.stuck_release_ms  <= RST_RELEASE;
      cfg_r.cruise_speed      <= RST_CRUISE;
      cfg_r.avoid_speed       <= RST_AVOID;
      cfg_r.manual_turn_speed <= RST_MTURN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/oadc_engine.sv =====
module oadc_engine
  import oadc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t res
);

  // Controller state
  logic [TimeW-1:0] time_r, time_nxt;
  logic [DistW-1:0] left_r, left_nxt;
  logic [DistW-1:0] front_r, front_nxt;
  logic [DistW-1:0] right_r, right_nxt;
  logic             auto_r, auto_nxt;
  logic [CmdW-1:0]  cmd_r, cmd_nxt;
  logic             stuck_r, stuck_nxt;
  logic [TimeW-1:0] begin_r, begin_nxt;

  // Auto-mode decision terms
  logic             fb, lb, rb, blocked, cornered;
  logic [TimeW-1:0] elapsed;
  logic             escape;
  logic             auto_stuck_nxt;
  logic [TimeW-1:0] auto_begin_nxt;
  result_t          auto_res;

  // Manual decode terms
  logic             man_valid;
  result_t          man_res;

  always_comb begin
    // State as seen by this transaction (updates apply first)
    time_nxt  = (item.mode == MODE_TICK) ? time_r + TimeW'(1) : time_r;
    left_nxt  = (item.mode == MODE_DIST) ? item.left_cm  : left_r;
    front_nxt = (item.mode == MODE_DIST) ? item.front_cm : front_r;
    right_nxt = (item.mode == MODE_DIST) ? item.right_cm : right_r;
    cmd_nxt   = (item.mode == MODE_CMD)  ? item.command_byte : cmd_r;

    // Blocked sides and stuck tracking
    fb       = front_nxt <= cfg.obstacle_distance;
    lb       = left_nxt  <= cfg.obstacle_distance;
    rb       = right_nxt <= cfg.obstacle_distance;
    blocked  = fb || lb || rb;
    cornered = (left_nxt <= cfg.corner_distance) && (right_nxt <= cfg.corner_distance);

    auto_begin_nxt = (blocked && !stuck_r) ? time_nxt : begin_r;
    elapsed        = time_nxt - auto_begin_nxt;
    escape         = blocked && (elapsed >= TimeW'(cfg.stuck_reverse_ms));
    auto_stuck_nxt = blocked;
    if (escape && (elapsed >= TimeW'(cfg.stuck_release_ms))) begin
      auto_stuck_nxt = 1'b0;
    end

    // Prioritized avoidance rules
    auto_res.motor_speed = cfg.avoid_speed;
    if (escape || cornered) begin
      auto_res.motor_action = ACT_BACK;
    end else if (fb && lb) begin
      auto_res.motor_action = ACT_RIGHT;
    end else if (fb && rb) begin
      auto_res.motor_action = ACT_LEFT;
    end else if (fb) begin
      auto_res.motor_action = (left_nxt > right_nxt) ? ACT_LEFT : ACT_RIGHT;
    end else if (lb) begin
      auto_res.motor_action = ACT_RIGHT;
    end else if (rb) begin
      auto_res.motor_action = ACT_LEFT;
    end else begin
      auto_res.motor_action = ACT_FWD;
      auto_res.motor_speed  = cfg.cruise_speed;
    end

    // Manual command decode, either case
    man_valid           = 1'b1;
    man_res.motor_speed = cfg.cruise_speed;
    case (cmd_nxt)
      "F", "f": man_res.motor_action = ACT_FWD;
      "B", "b": man_res.motor_action = ACT_BACK;
      "L", "l": begin
        man_res.motor_action = ACT_LEFT;
        man_res.motor_speed  = cfg.manual_turn_speed;
      end
      "R", "r": begin
        man_res.motor_action = ACT_RIGHT;
        man_res.motor_speed  = cfg.manual_turn_speed;
      end
      "S", "s": begin
        man_res.motor_action = ACT_STOP;
        man_res.motor_speed  = '0;
      end
      default: begin
        man_valid            = 1'b0;
        man_res.motor_action = ACT_STOP;
        man_res.motor_speed  = '0;
      end
    endcase

    // Per-event outcome
    auto_nxt  = auto_r;
    stuck_nxt = stuck_r;
    begin_nxt = begin_r;
    res_valid = 1'b0;
    res       = man_res;
    case (item.mode)
      MODE_TICK, MODE_DIST: begin
        if (auto_r) begin
          stuck_nxt = auto_stuck_nxt;
          begin_nxt = auto_begin_nxt;
          res_valid = 1'b1;
          res       = auto_res;
        end else if (item.mode == MODE_TICK) begin
          res_valid = man_valid;
        end
      end
      MODE_BUTTON: begin
        auto_nxt = !auto_r;
        if (auto_r) begin
          res_valid        = 1'b1;
          res.motor_action = ACT_STOP;
          res.motor_speed  = '0;
        end
      end
      MODE_CMD: res_valid = !auto_r && man_valid;
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r  <= '0;
      left_r  <= RST_DIST;
      front_r <= RST_DIST;
      right_r <= RST_DIST;
      auto_r  <= 1'b0;
      cmd_r   <= '0;
      stuck_r <= 1'b0;
      begin_r <= '0;
    end else if (fire) begin
      time_r  <= time_nxt;
      left_r  <= left_nxt;
      front_r <= front_nxt;
      right_r <= right_nxt;
      auto_r  <= auto_nxt;
      cmd_r   <= cmd_nxt;
      stuck_r <= stuck_nxt;
      begin_r <= begin_nxt;
    end
  end

endmodule

// ===== rtl/obstacle_avoid_drive_controller_unit.sv =====
// Drive controller for a two-wheel car. Each input transaction is one event
// (1 ms tick, distance update, auto button, remote command byte); it is
// captured in an input register, decided against the controller state and,
// when it yields a command, placed in the output register. One transaction
// is taken every cycle as long as the output register is free or being
// drained; the decision (stuck timer subtract and distance compares) is
// combinational. Configuration writes are taken at any time (cfg_ready is
// always high) and must only be issued while the block is idle.
module obstacle_avoid_drive_controller_unit
  import oadc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input events
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // left_cm, front_cm, right_cm, command_byte
  input  logic [ModeW-1:0]    in_tuser,   // mode
  // Motor commands
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // motor_action, motor_speed
  // Configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDatW-1:0]  cfg_data
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_valid_r;
  logic    out_valid_r;
  result_t out_r;
  logic    advance;
  logic    res_valid;
  result_t res;

  assign cfg_ready = 1'b1;

  oadc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Item moves on when the output register can take its result
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.mode         <= mode_e'(in_tuser);
      item_r.left_cm      <= in_tdata[8:0];
      item_r.front_cm     <= in_tdata[17:9];
      item_r.right_cm     <= in_tdata[26:18];
      item_r.command_byte <= in_tdata[34:27];
    end
  end

  oadc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.motor_speed, out_r.motor_action};

endmodule
